/* hw/rtl/gwa_pkg.sv */
// Shared types and constants for the gated window average block.
// No dependencies; used by gated_window_average_top.
package gwa_pkg;

    localparam int unsigned DIST_W   = 16;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned AVG_W    = 20;
    localparam int unsigned ECNT_W   = 5;
    localparam int unsigned FRAC_W   = 4;

    // APB register map: one 32-bit word per register
    localparam int unsigned PADDR_W  = 3;
    localparam int unsigned PDATA_W  = 32;

    localparam logic REG_MIN_DISTANCE = 1'b0;
    localparam logic REG_MAX_DISTANCE = 1'b1;

    localparam logic [DIST_W-1:0] MIN_DISTANCE_RST = 16'd30;
    localparam logic [DIST_W-1:0] MAX_DISTANCE_RST = 16'd2000;

    localparam logic [STATUS_W-1:0] STATUS_STORED   = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_TIMEOUT  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_RANGE    = 2'd2;

    localparam logic [ECNT_W-1:0] ECNT_MAX = 5'd31;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic              timed_out;
    } in_beat_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [AVG_W-1:0]    average_q4;
        logic                average_valid;
        logic [ECNT_W-1:0]   entry_count;
    } out_beat_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_DIVIDE,
        ST_DELIVER
    } gwa_state_t;

endpackage

/* hw/rtl/gwa_ram.sv */
// Generic single-clock RAM, one write port and one registered read port.
// No dependencies.
module gwa_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 16
) (
    input  logic                                      aclk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* hw/rtl/gated_window_average_top.sv */
// Gated moving average of range samples over a ring of recent distances.
// Sequence: a stored beat goes from accept through the update and divide states to
// deliver; a rejected beat skips update (DVD_W = 20 + clog2(RING_DEPTH+1) quotient bits).
// Throughput: s_ready is high only in idle and returns as m_valid rises, so one beat is
// in flight at a time; a result stall holds it off, and the bit-serial divider paces it.
// Reset: synchronous, active low; ring reads as zero via per-entry valid flags, so no
// clearing pass is needed and s_ready is high in the first cycle after reset.
// Depends on gwa_pkg and gwa_ram.
module gated_window_average_top #(
    parameter int unsigned RING_DEPTH = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // input beats
    input  logic                          s_valid,
    output logic                          s_ready,
    input  gwa_pkg::in_beat_t             s_data,
    // result beats
    output logic                          m_valid,
    input  logic                          m_ready,
    output gwa_pkg::out_beat_t            m_data,
    // APB configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [gwa_pkg::PADDR_W-1:0]   paddr,
    input  logic [gwa_pkg::PDATA_W-1:0]   pwdata,
    output logic [gwa_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);

    // ------------------------------------------------------------------
    // Derived widths
    // ------------------------------------------------------------------
    localparam int unsigned PTR_W  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int unsigned CNT_W  = $clog2(RING_DEPTH + 1);        // holds 0..RING_DEPTH
    localparam int unsigned SUM_W  = gwa_pkg::DIST_W + CNT_W;       // running sum of entries
    localparam int unsigned DVD_W  = SUM_W + gwa_pkg::FRAC_W;       // sum in q4
    localparam int unsigned STEP_W = $clog2(DVD_W + 1);
    localparam int unsigned XCNT_W = CNT_W + gwa_pkg::ECNT_W;       // room for saturation test

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    gwa_pkg::gwa_state_t state_reg, state_next;

    logic [gwa_pkg::DIST_W-1:0]   min_reg, min_next;
    logic [gwa_pkg::DIST_W-1:0]   max_reg, max_next;

    logic [gwa_pkg::DIST_W-1:0]   dist_reg, dist_next;
    logic [gwa_pkg::STATUS_W-1:0] status_reg, status_next;

    logic [PTR_W-1:0]             wp_reg, wp_next;
    logic [RING_DEPTH-1:0]        valid_reg, valid_next;

    // running sum and count of nonzero ring entries, kept up to date on every store
    logic [SUM_W-1:0]             sum_reg, sum_next;
    logic [CNT_W-1:0]             count_reg, count_next;

    // restoring divider: quotient bits shift in as the dividend shifts out
    logic [DVD_W-1:0]             dvd_reg, dvd_next;
    logic [CNT_W-1:0]             rem_reg, rem_next;
    logic [STEP_W-1:0]            step_reg, step_next;

    gwa_pkg::out_beat_t           out_reg, out_next;
    logic                         m_valid_reg, m_valid_next;

    // ------------------------------------------------------------------
    // Sequencer controls
    // ------------------------------------------------------------------
    logic in_fire;
    logic ram_we;
    logic upd_en;
    logic div_en;
    logic out_load;
    logic cfg_wr;

    logic [gwa_pkg::STATUS_W-1:0] in_status;
    logic [gwa_pkg::DIST_W-1:0]   ram_rdata;
    logic [gwa_pkg::DIST_W-1:0]   old_val;
    logic [SUM_W-1:0]             sum_upd;
    logic [CNT_W-1:0]             count_upd;
    logic [CNT_W:0]               trial;
    logic                         trial_ge;
    logic [XCNT_W-1:0]            count_x;

    // ------------------------------------------------------------------
    // Ring store: write at the write pointer, read of the same slot runs
    // every cycle so the old entry is ready the cycle after a beat lands.
    // ------------------------------------------------------------------
    gwa_ram #(
        .WIDTH (gwa_pkg::DIST_W),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (wp_reg),
        .wdata (dist_reg),
        .raddr (wp_reg),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Input gating: timeout wins over the range check
    // ------------------------------------------------------------------
    always_comb begin
        if (s_data.timed_out) begin
            in_status = gwa_pkg::STATUS_TIMEOUT;
        end else if ((s_data.distance < min_reg) || (s_data.distance > max_reg)) begin
            in_status = gwa_pkg::STATUS_RANGE;
        end else begin
            in_status = gwa_pkg::STATUS_STORED;
        end
    end

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            gwa_pkg::ST_IDLE: begin
                if (s_valid) begin
                    if (in_status == gwa_pkg::STATUS_STORED) begin
                        state_next = gwa_pkg::ST_UPDATE;
                    end else begin
                        state_next = gwa_pkg::ST_DIVIDE;
                    end
                end
            end
            gwa_pkg::ST_UPDATE: begin
                state_next = gwa_pkg::ST_DIVIDE;
            end
            gwa_pkg::ST_DIVIDE: begin
                if (step_reg == '0) begin
                    state_next = gwa_pkg::ST_DELIVER;
                end
            end
            gwa_pkg::ST_DELIVER: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = gwa_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = gwa_pkg::ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer outputs
    // ------------------------------------------------------------------
    always_comb begin
        s_ready  = 1'b0;
        ram_we   = 1'b0;
        upd_en   = 1'b0;
        div_en   = 1'b0;
        out_load = 1'b0;
        case (state_reg)
            gwa_pkg::ST_IDLE: begin
                s_ready = 1'b1;
            end
            gwa_pkg::ST_UPDATE: begin
                ram_we = 1'b1;
                upd_en = 1'b1;
            end
            gwa_pkg::ST_DIVIDE: begin
                div_en = 1'b1;
            end
            gwa_pkg::ST_DELIVER: begin
                out_load = !m_valid_reg || m_ready;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    assign in_fire = s_valid && s_ready;

    // ------------------------------------------------------------------
    // Configuration port; low address bits are ignored (word decode)
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        min_next = min_reg;
        max_next = max_reg;
        if (cfg_wr) begin
            if (paddr[2] == gwa_pkg::REG_MIN_DISTANCE) begin
                min_next = pwdata[gwa_pkg::DIST_W-1:0];
            end else begin
                max_next = pwdata[gwa_pkg::DIST_W-1:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == gwa_pkg::REG_MIN_DISTANCE) begin
            prdata = gwa_pkg::PDATA_W'(min_reg);
        end else begin
            prdata = gwa_pkg::PDATA_W'(max_reg);
        end
    end

    // ------------------------------------------------------------------
    // Ring update: swap the old entry out of the running sum and count.
    // An entry never written reads as zero.
    // ------------------------------------------------------------------
    assign old_val   = valid_reg[wp_reg] ? ram_rdata : '0;
    assign sum_upd   = sum_reg - SUM_W'(old_val) + SUM_W'(dist_reg);
    assign count_upd = count_reg - CNT_W'(old_val != '0) + CNT_W'(dist_reg != '0);

    // divider step
    assign trial    = {rem_reg, dvd_reg[DVD_W-1]};
    assign trial_ge = trial >= {1'b0, count_reg};

    assign count_x = XCNT_W'(count_reg);

    always_comb begin
        dist_next   = dist_reg;
        status_next = status_reg;
        wp_next     = wp_reg;
        valid_next  = valid_reg;
        sum_next    = sum_reg;
        count_next  = count_reg;
        dvd_next    = dvd_reg;
        rem_next    = rem_reg;
        step_next   = step_reg;

        if (in_fire) begin
            dist_next   = s_data.distance;
            status_next = in_status;
            // rejected beats divide the current ring straight away
            dvd_next    = {sum_reg, gwa_pkg::FRAC_W'(0)};
            rem_next    = '0;
            step_next   = STEP_W'(DVD_W - 1);
        end

        if (upd_en) begin
            sum_next           = sum_upd;
            count_next         = count_upd;
            valid_next[wp_reg] = 1'b1;
            if (wp_reg == PTR_W'(RING_DEPTH - 1)) begin
                wp_next = '0;
            end else begin
                wp_next = wp_reg + 1'b1;
            end
            dvd_next  = {sum_upd, gwa_pkg::FRAC_W'(0)};
            rem_next  = '0;
            step_next = STEP_W'(DVD_W - 1);
        end

        if (div_en) begin
            dvd_next  = {dvd_reg[DVD_W-2:0], trial_ge};
            rem_next  = trial_ge ? CNT_W'(trial - {1'b0, count_reg}) : trial[CNT_W-1:0];
            step_next = step_reg - 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Output register: holds the finished beat until taken
    // ------------------------------------------------------------------
    always_comb begin
        out_next     = out_reg;
        m_valid_next = m_valid_reg;
        if (out_load) begin
            out_next.status        = status_reg;
            out_next.average_q4    = (count_reg == '0) ? '0 : dvd_reg[gwa_pkg::AVG_W-1:0];
            out_next.average_valid = (count_reg != '0);
            out_next.entry_count   = (count_x > XCNT_W'(gwa_pkg::ECNT_MAX)) ?
                                     gwa_pkg::ECNT_MAX : count_x[gwa_pkg::ECNT_W-1:0];
            m_valid_next           = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= gwa_pkg::ST_IDLE;
            min_reg     <= gwa_pkg::MIN_DISTANCE_RST;
            max_reg     <= gwa_pkg::MAX_DISTANCE_RST;
            wp_reg      <= '0;
            valid_reg   <= '0;
            sum_reg     <= '0;
            count_reg   <= '0;
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            min_reg     <= min_next;
            max_reg     <= max_next;
            wp_reg      <= wp_next;
            valid_reg   <= valid_next;
            sum_reg     <= sum_next;
            count_reg   <= count_next;
            step_reg    <= step_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        dist_reg   <= dist_next;
        status_reg <= status_next;
        dvd_reg    <= dvd_next;
        rem_reg    <= rem_next;
        out_reg    <= out_next;
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(RING_DEPTH))
        else $error("entry count above ring depth");

    a_wp_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        wp_reg <= PTR_W'(RING_DEPTH - 1))
        else $error("write pointer past ring end");

    a_empty_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0) |-> (sum_reg == '0))
        else $error("nonzero sum with empty ring");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire |=> !s_ready)
        else $error("beat accepted while previous beat in flight");

    a_valid_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.average_valid == (m_data.entry_count != '0)))
        else $error("average_valid disagrees with entry_count");
`endif

endmodule
